// ===== design/dph_pkg.sv =====
// Shared types, constants and codes of the dimuon pair selection block.
`default_nettype none

package dph_pkg;

  localparam int NUM_BINS_DEF = 25;
  localparam int NUM_HISTS    = 8;
  localparam int LANES        = NUM_HISTS / 2;
  localparam int CNT_W        = 32;
  localparam int ETA_W        = 13;
  localparam int ETA_HALF     = 2600;
  localparam int ETA_FULL     = 5200;
  localparam int PT_W         = 9;
  localparam int QUAL_W       = 4;
  localparam int TIGHT_W      = 8;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  typedef enum logic [1:0] {
    FUNC_TRIG = 2'd0,
    FUNC_RECO = 2'd1,
    FUNC_EOE  = 2'd2,
    FUNC_READ = 2'd3
  } func_e;

  localparam logic [1:0] REG_LEAD_CUT  = 2'd0;
  localparam logic [1:0] REG_TRAIL_CUT = 2'd1;
  localparam logic [1:0] REG_MIN_QUAL  = 2'd2;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  // One memory row: the four histograms of one side at one bin.
  typedef logic [LANES-1:0][CNT_W-1:0] row_t;

  typedef struct packed {
    logic               pair;
    logic               cuts;
    logic               ghost;
    logic [TIGHT_W-1:0] tight;
  } evt_sum_t;

  // Held eta in offset form with its range flags.
  typedef struct packed {
    logic             under;
    logic             over;
    logic [ETA_W-1:0] off;
  } eta_pos_t;

endpackage

`default_nettype wire

// ===== design/dph_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface dph_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [8:0]        pt;
  logic signed [12:0] eta;
  logic [3:0]        quality;
  logic signed [2:0] bx;
  logic              tight;
  logic [2:0]        hist_select;
  logic [4:0]        bin_select;

  modport source (output valid, func, pt, eta, quality, bx, tight, hist_select, bin_select,
                  input ready);
  modport sink (input valid, func, pt, eta, quality, bx, tight, hist_select, bin_select,
                output ready);
endinterface

interface dph_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        pair_found;
  logic        cuts_passed;
  logic        ghost_flag;
  logic [4:0]  lead_bin;
  logic [4:0]  trail_bin;
  logic [7:0]  tight_total;
  logic [31:0] bin_count;

  modport source (output valid, kind, pair_found, cuts_passed, ghost_flag, lead_bin,
                  trail_bin, tight_total, bin_count, input ready);
  modport sink (input valid, kind, pair_found, cuts_passed, ghost_flag, lead_bin,
                trail_bin, tight_total, bin_count, output ready);
endinterface

`default_nettype wire

// ===== design/dimuon_pair_select_histogram.sv =====
// Top level: dimuon pair selection with eta histograms held in two memories.
//
//   channel   direction  handshake             contents
//   in_i      sink       valid/ready           func, pt, eta, quality, bx, tight, selects
//   out_o     source     valid/ready           summary or histogram readout item
//   APB       slave      psel/penable/pready   lead_pt_cut, trail_pt_cut, min_quality
//
// One item is accepted per cycle unless the output stalls. Trigger and reconstructed muon
// items update the event registers at once and give no result. End of event and readout
// items pass the stage one register and two memory stages (row read, then increment and
// write back) before they are loaded into the output register. The memories have one
// valid bit per row, so reset takes effect at once with no clearing pass. A stalled
// output lets the pipeline fill before input stops.
`default_nettype none

module dimuon_pair_select_histogram #(
  parameter int NUM_BINS = dph_pkg::NUM_BINS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  dph_in_if.sink                       in_i,
  dph_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dph_pkg::PADDR_W-1:0]  paddr,
  input  logic [dph_pkg::PDATA_W-1:0]  pwdata,
  output logic [dph_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import dph_pkg::*;

  localparam int ROWS = NUM_BINS + 2;
  localparam int RW   = $clog2(ROWS);
  localparam int QW   = $clog2(NUM_BINS);

  logic [PT_W-1:0]   lead_cut_q, trail_cut_q;
  logic [QUAL_W-1:0] min_qual_q;

  logic      in_acc;
  func_e     in_func;
  evt_sum_t  sum;
  eta_pos_t  lead_pos, trail_pos;
  logic [QW-1:0] lead_q0, trail_q0;

  logic          p1_v_q, p1_read_q;
  evt_sum_t      p1_sum_q;
  eta_pos_t      p1_lead_pos_q, p1_trail_pos_q;
  logic [QW-1:0] p1_lead_q0_q, p1_trail_q0_q;
  logic [2:0]    p1_hsel_q;
  logic [4:0]    p1_bsel_q;

  logic [RW-1:0] lead_bin, trail_bin;
  logic [RW-1:0] lead_bin_m, trail_bin_m;
  logic          bsel_ok;
  logic [RW-1:0] bsel_row;
  logic [RW-1:0] even_row, odd_row;
  logic          rd_en;

  logic          p2_v_q, p2_read_q, p2_bok_q;
  evt_sum_t      p2_sum_q;
  logic [RW-1:0] p2_lead_bin_q, p2_trail_bin_q;
  logic [2:0]    p2_hsel_q;

  row_t             even_data, odd_data;
  row_t             even_wr, odd_wr;
  logic [LANES-1:0] lane_en;
  logic [CNT_W-1:0] lane_val;
  logic             wr_en;

  logic out_v_q;
  logic out_free, p2_ready;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    return (x == '1) ? x : x + 1'b1;
  endfunction

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_cut_q  <= PT_W'(22);
      trail_cut_q <= PT_W'(8);
      min_qual_q  <= QUAL_W'(8);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_LEAD_CUT:  lead_cut_q  <= pwdata[PT_W-1:0];
        REG_TRAIL_CUT: trail_cut_q <= pwdata[PT_W-1:0];
        REG_MIN_QUAL:  min_qual_q  <= pwdata[QUAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LEAD_CUT:  prdata = PDATA_W'(lead_cut_q);
      REG_TRAIL_CUT: prdata = PDATA_W'(trail_cut_q);
      REG_MIN_QUAL:  prdata = PDATA_W'(min_qual_q);
      default:       prdata = '0;
    endcase
  end

  // Handshake.
  assign out_free   = !out_v_q || out_o.ready;
  assign p2_ready   = !p2_v_q || out_free;
  assign in_i.ready = !p1_v_q || p2_ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_func    = func_e'(in_i.func);

  dph_event #(.NUM_BINS(NUM_BINS)) u_event (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .func_i      (in_func),
    .pt_i        (in_i.pt),
    .eta_i       (in_i.eta),
    .quality_i   (in_i.quality),
    .bx_i        (in_i.bx),
    .tight_i     (in_i.tight),
    .lead_cut_i  (lead_cut_q),
    .trail_cut_i (trail_cut_q),
    .min_qual_i  (min_qual_q),
    .sum_o       (sum),
    .lead_pos_o  (lead_pos),
    .trail_pos_o (trail_pos),
    .lead_q0_o   (lead_q0),
    .trail_q0_o  (trail_q0)
  );

  // Stage one: event snapshot or readout request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (in_acc && (in_func == FUNC_EOE || in_func == FUNC_READ)) begin
      p1_v_q <= 1'b1;
    end else if (p2_ready) begin
      p1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1_read_q      <= in_func == FUNC_READ;
      p1_sum_q       <= sum;
      p1_lead_pos_q  <= lead_pos;
      p1_trail_pos_q <= trail_pos;
      p1_lead_q0_q   <= lead_q0;
      p1_trail_q0_q  <= trail_q0;
      p1_hsel_q      <= in_i.hist_select;
      p1_bsel_q      <= in_i.bin_select;
    end
  end

  dph_bin_fix #(.NUM_BINS(NUM_BINS)) u_lead_bin (
    .pos_i (p1_lead_pos_q),
    .q0_i  (p1_lead_q0_q),
    .bin_o (lead_bin)
  );

  dph_bin_fix #(.NUM_BINS(NUM_BINS)) u_trail_bin (
    .pos_i (p1_trail_pos_q),
    .q0_i  (p1_trail_q0_q),
    .bin_o (trail_bin)
  );

  // Even histograms live in the lead memory and odd ones in the trail memory.
  always_comb begin
    lead_bin_m  = p1_sum_q.pair ? lead_bin : '0;
    trail_bin_m = p1_sum_q.pair ? trail_bin : '0;
    bsel_ok     = 32'(p1_bsel_q) < 32'(ROWS);
    bsel_row    = bsel_ok ? RW'(p1_bsel_q) : '0;
    even_row    = p1_read_q ? bsel_row : lead_bin_m;
    odd_row     = p1_read_q ? bsel_row : trail_bin_m;
    rd_en       = p1_v_q && p2_ready;
  end

  // Stage two: row data back, increment and write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (rd_en) begin
      p2_v_q <= 1'b1;
    end else if (out_free) begin
      p2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      p2_read_q      <= p1_read_q;
      p2_bok_q       <= bsel_ok;
      p2_sum_q       <= p1_sum_q;
      p2_lead_bin_q  <= lead_bin_m;
      p2_trail_bin_q <= trail_bin_m;
      p2_hsel_q      <= p1_hsel_q;
    end
  end

  dph_hist_bank #(.ROWS(ROWS)) u_even_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_row_i  (even_row),
    .rd_data_o (even_data),
    .wr_en_i   (wr_en),
    .wr_row_i  (p2_lead_bin_q),
    .wr_data_i (even_wr)
  );

  dph_hist_bank #(.ROWS(ROWS)) u_odd_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_row_i  (odd_row),
    .rd_data_o (odd_data),
    .wr_en_i   (wr_en),
    .wr_row_i  (p2_trail_bin_q),
    .wr_data_i (odd_wr)
  );

  // Lanes in order: cut rate, open, ghost with cuts, ghost open.
  always_comb begin
    lane_en = {p2_sum_q.ghost, p2_sum_q.ghost && p2_sum_q.cuts, 1'b1, p2_sum_q.cuts};
    for (int k = 0; k < LANES; k++) begin
      even_wr[k] = lane_en[k] ? sat_inc(even_data[k]) : even_data[k];
      odd_wr[k]  = lane_en[k] ? sat_inc(odd_data[k]) : odd_data[k];
    end
    lane_val = p2_hsel_q[0] ? odd_data[p2_hsel_q[2:1]] : even_data[p2_hsel_q[2:1]];
    wr_en    = p2_v_q && out_free && !p2_read_q && p2_sum_q.pair;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (p2_v_q && out_free) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_v_q && out_free) begin
      if (p2_read_q) begin
        out_o.kind        <= KIND_READOUT;
        out_o.pair_found  <= 1'b0;
        out_o.cuts_passed <= 1'b0;
        out_o.ghost_flag  <= 1'b0;
        out_o.lead_bin    <= '0;
        out_o.trail_bin   <= '0;
        out_o.tight_total <= '0;
        out_o.bin_count   <= p2_bok_q ? lane_val : '0;
      end else begin
        out_o.kind        <= KIND_SUMMARY;
        out_o.pair_found  <= p2_sum_q.pair;
        out_o.cuts_passed <= p2_sum_q.cuts;
        out_o.ghost_flag  <= p2_sum_q.ghost;
        out_o.lead_bin    <= 5'(p2_lead_bin_q);
        out_o.trail_bin   <= 5'(p2_trail_bin_q);
        out_o.tight_total <= p2_sum_q.tight;
        out_o.bin_count   <= '0;
      end
    end
  end

  assign out_o.valid = out_v_q;

endmodule

`default_nettype wire

// ===== design/dph_event.sv =====
// Per-event top-two candidate selection, tight muon count and coarse eta quotient.
`default_nettype none

module dph_event #(
  parameter int NUM_BINS = dph_pkg::NUM_BINS_DEF,
  localparam int QW = $clog2(NUM_BINS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              acc_i,
  input  dph_pkg::func_e                    func_i,
  input  logic [dph_pkg::PT_W-1:0]          pt_i,
  input  logic signed [dph_pkg::ETA_W-1:0]  eta_i,
  input  logic [dph_pkg::QUAL_W-1:0]        quality_i,
  input  logic signed [2:0]                 bx_i,
  input  logic                              tight_i,
  input  logic [dph_pkg::PT_W-1:0]          lead_cut_i,
  input  logic [dph_pkg::PT_W-1:0]          trail_cut_i,
  input  logic [dph_pkg::QUAL_W-1:0]        min_qual_i,
  output dph_pkg::evt_sum_t                 sum_o,
  output dph_pkg::eta_pos_t                 lead_pos_o,
  output dph_pkg::eta_pos_t                 trail_pos_o,
  output logic [QW-1:0]                     lead_q0_o,
  output logic [QW-1:0]                     trail_q0_o
);
  import dph_pkg::*;

  localparam int SHIFT = 13;
  localparam int MN    = (NUM_BINS * (1 << SHIFT)) / ETA_FULL;
  localparam int MN_W  = $clog2(MN + 1);
  localparam int PW    = ETA_W + MN_W;

  logic [PT_W-1:0]    lead_pt_q, trail_pt_q;
  logic               lead_ok_q, trail_ok_q;
  logic [TIGHT_W-1:0] tight_q;
  eta_pos_t           lead_pos_q, trail_pos_q;
  logic [QW-1:0]      lead_q0_q, trail_q0_q;

  logic signed [ETA_W:0] off_s;
  eta_pos_t              new_pos;
  logic [PW-1:0]         prod;
  logic [QW-1:0]         new_q0;
  logic                  eligible;
  logic                  pair;

  // The reciprocal product lands on the true quotient or one below it.
  always_comb begin
    off_s         = (ETA_W + 1)'(eta_i) + (ETA_W + 1)'(ETA_HALF);
    new_pos.under = off_s < 0;
    new_pos.over  = off_s >= (ETA_W + 1)'(ETA_FULL);
    new_pos.off   = off_s[ETA_W-1:0];
    prod          = PW'(new_pos.off) * PW'(MN);
    new_q0        = prod[SHIFT +: QW];
    eligible      = (bx_i == 3'sd0) && (quality_i >= min_qual_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pt_q  <= '0;
      trail_pt_q <= '0;
      lead_ok_q  <= 1'b0;
      trail_ok_q <= 1'b0;
      tight_q    <= '0;
    end else if (acc_i) begin
      case (func_i)
        FUNC_TRIG: begin
          if (eligible && pt_i > lead_pt_q) begin
            trail_pt_q <= lead_pt_q;
            trail_ok_q <= lead_ok_q;
            lead_pt_q  <= pt_i;
            lead_ok_q  <= 1'b1;
          end else if (eligible && pt_i > trail_pt_q) begin
            trail_pt_q <= pt_i;
            trail_ok_q <= 1'b1;
          end
        end
        FUNC_RECO: begin
          if (tight_i && tight_q != '1) begin
            tight_q <= tight_q + 1'b1;
          end
        end
        FUNC_EOE: begin
          lead_pt_q  <= '0;
          trail_pt_q <= '0;
          lead_ok_q  <= 1'b0;
          trail_ok_q <= 1'b0;
          tight_q    <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && func_i == FUNC_TRIG && eligible) begin
      if (pt_i > lead_pt_q) begin
        trail_pos_q <= lead_pos_q;
        trail_q0_q  <= lead_q0_q;
        lead_pos_q  <= new_pos;
        lead_q0_q   <= new_q0;
      end else if (pt_i > trail_pt_q) begin
        trail_pos_q <= new_pos;
        trail_q0_q  <= new_q0;
      end
    end
  end

  always_comb begin
    pair        = lead_ok_q && trail_ok_q;
    sum_o.pair  = pair;
    sum_o.cuts  = pair && (lead_pt_q >= lead_cut_i) && (trail_pt_q >= trail_cut_i);
    sum_o.ghost = pair && (tight_q == TIGHT_W'(1));
    sum_o.tight = tight_q;
  end

  assign lead_pos_o  = lead_pos_q;
  assign trail_pos_o = trail_pos_q;
  assign lead_q0_o   = lead_q0_q;
  assign trail_q0_o  = trail_q0_q;

endmodule

`default_nettype wire

// ===== design/dph_bin_fix.sv =====
// Final eta bin from the coarse quotient, with one correction step and range flags.
`default_nettype none

module dph_bin_fix #(
  parameter int NUM_BINS = dph_pkg::NUM_BINS_DEF,
  localparam int QW = $clog2(NUM_BINS),
  localparam int RW = $clog2(NUM_BINS + 2)
) (
  input  dph_pkg::eta_pos_t pos_i,
  input  logic [QW-1:0]     q0_i,
  output logic [RW-1:0]     bin_o
);
  import dph_pkg::*;

  localparam int TW = ETA_W + $clog2(NUM_BINS + 1);

  logic [TW-1:0] scaled;
  logic [TW-1:0] limit;
  logic          bump;

  always_comb begin
    scaled = TW'(pos_i.off) * TW'(NUM_BINS);
    limit  = TW'(q0_i) * TW'(ETA_FULL) + TW'(ETA_FULL);
    bump   = scaled >= limit;
    if (pos_i.under) begin
      bin_o = '0;
    end else if (pos_i.over) begin
      bin_o = RW'(NUM_BINS + 1);
    end else begin
      bin_o = RW'(q0_i) + RW'(bump) + RW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== design/dph_hist_bank.sv =====
// One histogram memory: a row per bin, four saturating counters per row, with row valid
// bits and forwarding of the latest write.
`default_nettype none

module dph_hist_bank #(
  parameter int ROWS = dph_pkg::NUM_BINS_DEF + 2,
  localparam int RW = $clog2(ROWS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [RW-1:0] rd_row_i,
  output dph_pkg::row_t rd_data_o,
  input  logic          wr_en_i,
  input  logic [RW-1:0] wr_row_i,
  input  dph_pkg::row_t wr_data_i
);
  import dph_pkg::*;

  row_t            mem_q [ROWS];
  row_t            rd_q;
  logic [RW-1:0]   rd_row_q;
  logic            rd_ok_q;
  logic [ROWS-1:0] row_ok_q;
  logic            fwd_v_q;
  logic [RW-1:0]   fwd_row_q;
  row_t            fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i] <= wr_data_i;
      fwd_row_q       <= wr_row_i;
      fwd_data_q      <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q     <= mem_q[rd_row_i];
      rd_row_q <= rd_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_ok_q <= '0;
      rd_ok_q  <= 1'b0;
      fwd_v_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_ok_q[wr_row_i] <= 1'b1;
        fwd_v_q            <= 1'b1;
      end
      if (rd_en_i) begin
        rd_ok_q <= row_ok_q[rd_row_i];
      end
    end
  end

  // A write at the same edge as the read is missed by the read data; the forward register
  // always holds the most recent write.
  always_comb begin
    if (fwd_v_q && fwd_row_q == rd_row_q) begin
      rd_data_o = fwd_data_q;
    end else if (rd_ok_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_dimuon_pair_select_histogram.sv =====
// Self-checking testbench for the dimuon pair selection and eta histogram block.
module tb_dimuon_pair_select_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  import dph_pkg::*;

  localparam int NBINS       = NUM_BINS_DEF;
  localparam int HIST_BINS   = NBINS + 2;
  localparam int STUCK_LIMIT = 4000;
  localparam int SETTLE_CYC  = 6;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_ITEMS = 60;

  typedef struct packed {
    func_e              func;
    logic [PT_W-1:0]    pt;
    logic [ETA_W-1:0]   eta;
    logic [QUAL_W-1:0]  quality;
    logic [2:0]         bx;
    logic               tight;
    logic [2:0]         hist_sel;
    logic [4:0]         bin_sel;
  } muon_item_t;

  typedef struct packed {
    logic               kind;
    logic               pair;
    logic               cuts;
    logic               ghost;
    logic [4:0]         lead_bin;
    logic [4:0]         trail_bin;
    logic [TIGHT_W-1:0] tight_total;
    logic [CNT_W-1:0]   bin_count;
  } dimuon_report_t;

  typedef struct {
    muon_item_t     item;
    bit             fixed;
    dimuon_report_t fixed_rep;
  } stim_row_t;

  localparam dimuon_report_t SUMMARY_ZERO = '0;
  localparam dimuon_report_t READOUT_ZERO = '{kind: KIND_READOUT, default: '0};

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  dph_in_if  in_if ();
  dph_out_if out_if ();

  dimuon_pair_select_histogram #(.NUM_BINS(NBINS)) DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [PT_W-1:0]    cut_lead, cut_trail;
  logic [QUAL_W-1:0]  qual_min;
  logic [PT_W-1:0]    lead_pt, trail_pt;
  logic [ETA_W-1:0]   lead_eta, trail_eta;
  bit                 lead_ok, trail_ok;
  logic [TIGHT_W-1:0] tight_cnt;
  logic [CNT_W-1:0]   eta_hist [NUM_HISTS][HIST_BINS];
  logic [4:0]         last_lead_bin, last_trail_bin;

  dimuon_report_t report_q[$];
  dimuon_report_t seen_rep;
  stim_row_t      rows[$];

  int  errors, items_taken, results_seen, pairs_seen, settings_done, stuck;
  bit  calm, quiet;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic check_report(dimuon_report_t got, dimuon_report_t want);
    if (got.kind !== want.kind) report_mismatch("kind", 32'(got.kind), 32'(want.kind));
    if (got.pair !== want.pair)
      report_mismatch("pair_found", 32'(got.pair), 32'(want.pair));
    if (got.cuts !== want.cuts)
      report_mismatch("cuts_passed", 32'(got.cuts), 32'(want.cuts));
    if (got.ghost !== want.ghost)
      report_mismatch("ghost_flag", 32'(got.ghost), 32'(want.ghost));
    if (got.lead_bin !== want.lead_bin)
      report_mismatch("lead_bin", 32'(got.lead_bin), 32'(want.lead_bin));
    if (got.trail_bin !== want.trail_bin)
      report_mismatch("trail_bin", 32'(got.trail_bin), 32'(want.trail_bin));
    if (got.tight_total !== want.tight_total)
      report_mismatch("tight_total", 32'(got.tight_total), 32'(want.tight_total));
    if (got.bin_count !== want.bin_count)
      report_mismatch("bin_count", got.bin_count, want.bin_count);
  endtask

  function automatic logic [4:0] eta_to_bin(logic [ETA_W-1:0] raw);
    int e;
    e = $signed(raw);
    if (e < -ETA_HALF) return 5'd0;
    if (e >= ETA_HALF) return 5'(NBINS + 1);
    return 5'(1 + ((e + ETA_HALF) * NBINS) / ETA_FULL);
  endfunction

  task automatic bump(int h, logic [4:0] b);
    if (eta_hist[h][b] != '1) eta_hist[h][b] = eta_hist[h][b] + 32'd1;
  endtask

  task automatic clear_crossing();
    lead_pt = '0;
    trail_pt = '0;
    lead_eta = '0;
    trail_eta = '0;
    lead_ok = 0;
    trail_ok = 0;
    tight_cnt = '0;
  endtask

  task automatic model_pair_select(input muon_item_t it, output bit has,
                                   output dimuon_report_t rep);
    logic [4:0] lb, tb;
    bit pr, ct, gh;
    has = 0;
    rep = '0;
    lb = '0;
    tb = '0;
    case (it.func)
      FUNC_TRIG: begin
        if (it.bx == 3'b000 && it.quality >= qual_min) begin
          if (it.pt > lead_pt) begin
            trail_pt = lead_pt;
            trail_eta = lead_eta;
            trail_ok = lead_ok;
            lead_pt = it.pt;
            lead_eta = it.eta;
            lead_ok = 1;
          end else if (it.pt > trail_pt) begin
            trail_pt = it.pt;
            trail_eta = it.eta;
            trail_ok = 1;
          end
        end
      end
      FUNC_RECO: begin
        if (it.tight && tight_cnt != '1) tight_cnt = tight_cnt + 8'd1;
      end
      FUNC_EOE: begin
        pr = lead_ok && trail_ok;
        ct = pr && lead_pt >= cut_lead && trail_pt >= cut_trail;
        gh = pr && tight_cnt == 1;
        if (pr) begin
          lb = eta_to_bin(lead_eta);
          tb = eta_to_bin(trail_eta);
          if (ct) begin
            bump(0, lb);
            bump(1, tb);
          end
          bump(2, lb);
          bump(3, tb);
          if (gh) begin
            if (ct) begin
              bump(4, lb);
              bump(5, tb);
            end
            bump(6, lb);
            bump(7, tb);
          end
          pairs_seen++;
          last_lead_bin = lb;
          last_trail_bin = tb;
        end
        has = 1;
        rep.kind = KIND_SUMMARY;
        rep.pair = pr;
        rep.cuts = ct;
        rep.ghost = gh;
        rep.lead_bin = lb;
        rep.trail_bin = tb;
        rep.tight_total = tight_cnt;
        clear_crossing();
      end
      default: begin
        has = 1;
        rep.kind = KIND_READOUT;
        if (it.bin_sel < HIST_BINS) rep.bin_count = eta_hist[it.hist_sel][it.bin_sel];
      end
    endcase
  endtask

  task automatic send_item(muon_item_t it, bit fixed, dimuon_report_t fixed_rep);
    bit has;
    dimuon_report_t rep;
    @(negedge clk);
    if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_if.func = it.func;
    in_if.pt = it.pt;
    in_if.eta = it.eta;
    in_if.quality = it.quality;
    in_if.bx = it.bx;
    in_if.tight = it.tight;
    in_if.hist_select = it.hist_sel;
    in_if.bin_select = it.bin_sel;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    items_taken++;
    model_pair_select(it, has, rep);
    if (has) report_q = {report_q, fixed ? fixed_rep : rep};
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic apb_access(logic [1:0] idx, bit wr, logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr) begin
      case (idx)
        REG_LEAD_CUT:  if (prdata !== PDATA_W'(cut_lead))
                         report_mismatch("lead_pt_cut readback", prdata, 32'(cut_lead));
        REG_TRAIL_CUT: if (prdata !== PDATA_W'(cut_trail))
                         report_mismatch("trail_pt_cut readback", prdata, 32'(cut_trail));
        default:       if (prdata !== PDATA_W'(qual_min))
                         report_mismatch("min_quality readback", prdata, 32'(qual_min));
      endcase
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic write_cuts(int lead, int trail, int qual);
    logic [PDATA_W-1:0] junk;
    junk = $urandom;
    apb_access(REG_LEAD_CUT, 1, {junk[31:9], 9'(lead)});
    cut_lead = 9'(lead);
    junk = $urandom;
    apb_access(REG_TRAIL_CUT, 1, {junk[31:9], 9'(trail)});
    cut_trail = 9'(trail);
    junk = $urandom;
    apb_access(REG_MIN_QUAL, 1, {junk[31:4], 4'(qual)});
    qual_min = 4'(qual);
    apb_access(REG_LEAD_CUT, 0, '0);
    apb_access(REG_TRAIL_CUT, 0, '0);
    apb_access(REG_MIN_QUAL, 0, '0);
    settings_done++;
  endtask

  function automatic stim_row_t mk_row(func_e f, int pt, int eta, int q, int bx, bit tight,
                                       int hs, int bs, bit fixed, dimuon_report_t rep);
    stim_row_t r;
    r.item = '{func: f, pt: 9'(pt), eta: 13'(eta), quality: 4'(q), bx: 3'(bx),
               tight: tight, hist_sel: 3'(hs), bin_sel: 5'(bs)};
    r.fixed = fixed;
    r.fixed_rep = rep;
    return r;
  endfunction

  function automatic muon_item_t rand_item_bits();
    muon_item_t it;
    it.func = func_e'($urandom_range(0, 3));
    it.pt = 9'($urandom);
    it.eta = 13'($urandom);
    it.quality = 4'($urandom);
    it.bx = 3'($urandom);
    it.tight = 1'($urandom);
    it.hist_sel = 3'($urandom);
    it.bin_sel = 5'($urandom);
    return it;
  endfunction

  function automatic muon_item_t trig_item();
    muon_item_t it;
    int e;
    bit eligible;
    it = rand_item_bits();
    it.func = FUNC_TRIG;
    eligible = $urandom_range(0, 3) != 0;
    case ($urandom_range(0, 7))
      0: it.pt = '0;
      1: it.pt = '1;
      2: it.pt = 9'($urandom_range(1, 30));
      default: it.pt = 9'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0: e = $signed(13'($urandom));
      1: begin
        case ($urandom_range(0, 7))
          0: e = -2601;
          1: e = -2600;
          2: e = -1;
          3: e = 0;
          4: e = 2599;
          5: e = 2600;
          6: e = -4096;
          default: e = 4095;
        endcase
      end
      default: e = int'($urandom_range(0, 6000)) - 3000;
    endcase
    it.eta = 13'(e);
    if (eligible) begin
      it.quality = 4'($urandom_range(int'(qual_min), 15));
      it.bx = 3'b000;
    end
    return it;
  endfunction

  function automatic muon_item_t reco_item();
    muon_item_t it;
    it = rand_item_bits();
    it.func = FUNC_RECO;
    it.tight = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic muon_item_t read_item();
    muon_item_t it;
    it = rand_item_bits();
    it.func = FUNC_READ;
    case ($urandom_range(0, 3))
      0: it.bin_sel = last_lead_bin;
      1: it.bin_sel = last_trail_bin;
      2: it.bin_sel = 5'($urandom_range(0, 31));
      default: it.bin_sel = 5'($urandom_range(0, HIST_BINS - 1));
    endcase
    return it;
  endfunction

  task automatic send_collision();
    int n_trig, n_reco;
    muon_item_t it;
    quiet = $urandom_range(0, 3) == 0;
    if ($urandom_range(0, 7) == 0) begin
      send_item(rand_item_bits(), 0, '0);
      return;
    end
    n_trig = $urandom_range(0, 5);
    n_reco = $urandom_range(0, 3);
    while (n_trig + n_reco > 0) begin
      if (n_trig > 0 && (n_reco == 0 || $urandom_range(0, 1) == 1)) begin
        send_item(trig_item(), 0, '0);
        n_trig--;
      end else begin
        send_item(reco_item(), 0, '0);
        n_reco--;
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      it = rand_item_bits();
      it.func = FUNC_EOE;
      send_item(it, 0, '0);
    end
    if ($urandom_range(0, 2) == 0) send_item(read_item(), 0, '0);
  endtask

  task automatic saturate_tight();
    muon_item_t it;
    quiet = 1;
    repeat (258) begin
      it = reco_item();
      it.tight = 1'b1;
      send_item(it, 0, '0);
    end
    repeat (2) begin
      it = trig_item();
      it.pt = 9'($urandom_range(1, 511));
      it.quality = 4'hF;
      it.bx = 3'b000;
      send_item(it, 0, '0);
    end
    it = rand_item_bits();
    it.func = FUNC_EOE;
    send_item(it, 0, '0);
    quiet = 0;
  endtask

  initial begin
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (calm) begin
        out_if.ready = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        seen_rep = '{kind: out_if.kind, pair: out_if.pair_found, cuts: out_if.cuts_passed,
                     ghost: out_if.ghost_flag, lead_bin: out_if.lead_bin,
                     trail_bin: out_if.trail_bin, tight_total: out_if.tight_total,
                     bin_count: out_if.bin_count};
        results_seen++;
        if (report_q.size() == 0) report_mismatch("result with nothing pending", 1, 0);
        else check_report(seen_rep, report_q.pop_front());
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) stuck = 0;
      else stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STUCK_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int lead_set[NUM_PHASES]  = '{0, 511, 0, 22, 511, 0, 0};
    int trail_set[NUM_PHASES] = '{0, 511, 0, 8, 0, 0, 511};
    int qual_set[NUM_PHASES]  = '{0, 15, 0, 8, 8, 0, 0};
    int start;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.func = FUNC_TRIG;
    in_if.pt = '0;
    in_if.eta = '0;
    in_if.quality = '0;
    in_if.bx = '0;
    in_if.tight = 1'b0;
    in_if.hist_select = '0;
    in_if.bin_select = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 0;
    quiet = 0;
    cut_lead = 9'd22;
    cut_trail = 9'd8;
    qual_min = 4'd8;
    clear_crossing();
    foreach (eta_hist[h, b]) eta_hist[h][b] = '0;
    last_lead_bin = '0;
    last_trail_bin = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    rows = {rows, mk_row(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 1, READOUT_ZERO)};
    rows = {rows, mk_row(FUNC_EOE, 0, 0, 0, 0, 0, 0, 0, 1, SUMMARY_ZERO)};
    rows = {rows, mk_row(FUNC_READ, 511, 4095, 15, 3, 1, 7, 26, 1, READOUT_ZERO)};
    rows = {rows, mk_row(FUNC_READ, 0, 0, 0, 0, 0, 3, 31, 1, READOUT_ZERO)};
    rows = {rows, mk_row(FUNC_TRIG, 511, -4096, 15, 0, 0, 0, 0, 0, '0)};
    rows = {rows, mk_row(FUNC_TRIG, 0, 100, 15, 0, 1, 7, 31, 0, '0)};
    rows = {rows, mk_row(FUNC_EOE, 0, 0, 0, 0, 0, 0, 0, 1, SUMMARY_ZERO)};
    rows = {rows, mk_row(FUNC_TRIG, 300, 4095, 15, 1, 0, 0, 0, 0, '0)};
    rows = {rows, mk_row(FUNC_TRIG, 300, 2599, 7, 0, 0, 0, 0, 0, '0)};
    rows = {rows, mk_row(FUNC_TRIG, 300, 2600, 8, 0, 0, 0, 0, 0, '0)};
    rows = {rows, mk_row(FUNC_TRIG, 300, -2600, 8, 0, 0, 0, 0, 0, '0)};
    rows = {rows, mk_row(FUNC_TRIG, 400, -2601, 8, -4, 0, 0, 0, 0, '0)};
    rows = {rows, mk_row(FUNC_RECO, 0, 0, 0, 0, 1, 0, 0, 0, '0)};
    rows = {rows, mk_row(FUNC_RECO, 0, 0, 0, 0, 0, 0, 0, 0, '0)};
    rows = {rows, mk_row(FUNC_EOE, 0, 0, 0, 0, 0, 0, 0, 0, '0)};
    rows = {rows, mk_row(FUNC_READ, 0, 0, 0, 0, 0, 6, 26, 0, '0)};
    rows = {rows, mk_row(FUNC_READ, 0, 0, 0, 0, 0, 5, 1, 0, '0)};
    rows = {rows, mk_row(FUNC_TRIG, 21, 0, 8, 0, 0, 0, 0, 0, '0)};
    rows = {rows, mk_row(FUNC_TRIG, 7, -1, 9, 0, 0, 0, 0, 0, '0)};
    rows = {rows, mk_row(FUNC_RECO, 0, 0, 0, 0, 1, 0, 0, 0, '0)};
    rows = {rows, mk_row(FUNC_RECO, 0, 0, 0, 0, 1, 0, 0, 0, '0)};
    rows = {rows, mk_row(FUNC_EOE, 0, 0, 0, 0, 0, 0, 0, 0, '0)};
    rows = {rows, mk_row(FUNC_READ, 0, 0, 0, 0, 0, 2, 13, 0, '0)};
    rows = {rows, mk_row(FUNC_READ, 0, 0, 0, 0, 0, 0, 13, 0, '0)};
    foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].fixed_rep);

    lead_set[2] = $urandom_range(0, 511);
    trail_set[2] = $urandom_range(0, 511);
    qual_set[2] = $urandom_range(0, 15);
    lead_set[5] = $urandom_range(0, 60);
    trail_set[5] = $urandom_range(0, 30);
    qual_set[5] = $urandom_range(0, 15);
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_cuts(lead_set[p], trail_set[p], qual_set[p]);
      calm = p == NUM_PHASES - 1;
      if (p == 3) saturate_tight();
      start = items_taken;
      while (items_taken - start < PHASE_ITEMS) send_collision();
    end

    @(negedge clk);
    in_if.valid = 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC + 2) @(posedge clk);
    $display("covered %0d items and %0d results, %0d crossings with a pair,", items_taken,
             results_seen, pairs_seen);
    $display("under %0d register settings; %0d mismatches", settings_done, errors);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
